@@ design/rope_pkg.sv @@
// shared types, constants and the rate function for the rotary position embedding block
// no dependencies
`default_nettype none

package rope_pkg;

    localparam int HEAD_DIM_DEFAULT    = 128;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [63:0] LOG2_10000_Q32 = 64'd57070290109;
    localparam logic [63:0] LN2_Q32        = 64'd2977044472;
    localparam logic [63:0] INV_2PI_Q32    = 64'd683565276;
    localparam logic [32:0] HALF_PI_Q32    = 33'd6746518852;

    localparam int NUM_PAIRS = 128;
    localparam int SIN_TERMS = 8;

    typedef struct packed {
        logic signed [31:0] even_value;
        logic signed [31:0] odd_value;
        logic        [6:0]  pair_index;
        logic        [15:0] position;
    } rope_in_t;

    typedef struct packed {
        logic signed [31:0] rotated_even;
        logic signed [31:0] rotated_odd;
        logic               saturated;
    } rope_out_t;

    typedef struct packed {
        logic signed [31:0] even_value;
        logic signed [31:0] odd_value;
        logic        [31:0] phase;
    } rope_work_t;

    // turns per position from the frequency exponent in Q32.32
    function automatic logic [31:0] rate_from_exp(input logic [63:0] expo);
        logic [127:0] n;
        logic [127:0] f;
        logic [127:0] x;
        logic [127:0] sum;
        logic [127:0] term;
        logic [127:0] t;
        logic [127:0] r;
        n    = 128'(expo >> 32);
        f    = 128'(expo[31:0]);
        x    = (f * 128'(LN2_Q32)) >> 32;
        sum  = 128'd1 << 32;
        term = 128'd1 << 32;
        for (int k = 1; k <= 14; k++)
        begin
            term = ((term * x) >> 32) / 128'(k);
            if (k % 2 == 1)
                sum = sum - term;
            else
                sum = sum + term;
        end
        t = (sum * 128'(INV_2PI_Q32) + (128'd1 << 31)) >> 32;
        if (n >= 128'd32)
            r = '0;
        else
            r = (t + ((128'd1 << n) >> 1)) >> n;
        return r[31:0];
    endfunction

endpackage

`default_nettype wire

@@ design/rope_front.sv @@
// front end: takes input beats, looks up the rotation rate and forms the phase
// depends on rope_pkg
`default_nettype none

module rope_front #(
    parameter int HEAD_DIM = rope_pkg::HEAD_DIM_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire rope_pkg::rope_in_t   item,
    output logic                      work_push,
    output rope_pkg::rope_work_t      work,
    input  wire logic                 work_full
);
    import rope_pkg::*;

    logic [31:0] rate_tab [NUM_PAIRS];

    for (genvar j = 0; j < NUM_PAIRS; j++)
    begin : g_rate
        localparam logic [63:0] EXPO = (64'(2 * j) * LOG2_10000_Q32) / 64'(HEAD_DIM);
        assign rate_tab[j] = rate_from_exp(EXPO);
    end

    logic        f_valid_reg;
    rope_work_t  f_reg;
    logic [47:0] phase_prod;
    logic        take;

    assign phase_prod = 48'(rate_tab[item.pair_index]) * 48'(item.position);
    assign full       = f_valid_reg && work_full;
    assign take       = push && !full;
    assign work_push  = f_valid_reg && !work_full;
    assign work       = f_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            f_valid_reg <= 1'b0;
        else if (take)
            f_valid_reg <= 1'b1;
        else if (work_push)
            f_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            f_reg.even_value <= item.even_value;
            f_reg.odd_value  <= item.odd_value;
            f_reg.phase      <= phase_prod[31:0];
        end
    end

endmodule

`default_nettype wire

@@ design/rope_queue.sv @@
// short queue of phase beats between front and back
// depends on rope_pkg
`default_nettype none

module rope_queue #(
    parameter int QUEUE_DEPTH = rope_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  wr_en,
    input  wire rope_pkg::rope_work_t  wr_data,
    output logic                       q_full,
    input  wire logic                  rd_en,
    output rope_pkg::rope_work_t       rd_data,
    output logic                       q_empty
);
    import rope_pkg::*;

    localparam int AW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    rope_work_t    mem_reg [QUEUE_DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] rd_ptr_reg;
    logic [CW-1:0] count_reg;
    logic          do_wr;
    logic          do_rd;

    assign q_full  = (count_reg == CW'(QUEUE_DEPTH));
    assign q_empty = (count_reg == '0);
    assign do_wr   = wr_en && !q_full;
    assign do_rd   = rd_en && !q_empty;
    assign rd_data = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_wr)
                wr_ptr_reg <= (wr_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (do_rd)
                rd_ptr_reg <= (rd_ptr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (do_wr && !do_rd)
                count_reg <= count_reg + 1'b1;
            else if (do_rd && !do_wr)
                count_reg <= count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_wr)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

endmodule

`default_nettype wire

@@ design/rope_back.sv @@
// back end: series sine and cosine pipeline, pair rotation, rounding and output register
// depends on rope_pkg
`default_nettype none

module rope_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire rope_pkg::rope_work_t  work,
    input  wire logic                  work_empty,
    output logic                       work_pop,
    output rope_pkg::rope_out_t        result,
    output logic                       empty,
    input  wire logic                  pop
);
    import rope_pkg::*;

    localparam int TW = 33;
    localparam int SW = 36;
    localparam int MW = 42;
    localparam int NB = SIN_TERMS + 1;

    logic en;
    logic out_valid_reg;

    assign en       = !out_valid_reg || pop;
    assign work_pop = en && !work_empty;
    assign empty    = !out_valid_reg;

    // stage 1: angle in radians
    logic               v1_reg;
    logic signed [31:0] e1_reg, o1_reg;
    logic [1:0]         q1_reg;
    logic [30:0]        th1_reg;
    logic [62:0]        th_prod;

    assign th_prod = 63'(work.phase[29:0]) * 63'(HALF_PI_Q32);

    // series stages, b index k holds the state after k terms
    logic               vb_reg  [NB];
    logic signed [31:0] eb_reg  [NB];
    logic signed [31:0] ob_reg  [NB];
    logic [1:0]         qb_reg  [NB];
    logic [31:0]        t2b_reg [NB];
    logic [TW-1:0]      tsb_reg [NB];
    logic [TW-1:0]      tcb_reg [NB];
    logic signed [SW-1:0] svb_reg [NB];
    logic signed [SW-1:0] cvb_reg [NB];

    logic               va_reg  [SIN_TERMS];
    logic signed [31:0] ea_reg  [SIN_TERMS];
    logic signed [31:0] oa_reg  [SIN_TERMS];
    logic [1:0]         qa_reg  [SIN_TERMS];
    logic [31:0]        t2a_reg [SIN_TERMS];
    logic [TW-1:0]      psa_reg [SIN_TERMS];
    logic [TW-1:0]      pca_reg [SIN_TERMS];
    logic signed [SW-1:0] sva_reg [SIN_TERMS];
    logic signed [SW-1:0] cva_reg [SIN_TERMS];

    logic [61:0] th2_prod;
    assign th2_prod = 62'(th1_reg) * 62'(th1_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            vb_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= work_pop;
            vb_reg[0] <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            e1_reg     <= work.even_value;
            o1_reg     <= work.odd_value;
            q1_reg     <= work.phase[31:30];
            th1_reg    <= th_prod[62:32];
            eb_reg[0]  <= e1_reg;
            ob_reg[0]  <= o1_reg;
            qb_reg[0]  <= q1_reg;
            t2b_reg[0] <= th2_prod[61:30];
            tsb_reg[0] <= TW'(th1_reg);
            tcb_reg[0] <= TW'(1) << 30;
            svb_reg[0] <= SW'(th1_reg);
            cvb_reg[0] <= SW'(1) << 30;
        end
    end

    for (genvar k = 0; k < SIN_TERMS; k++)
    begin : g_term
        localparam logic [63:0] DS = 64'((2 * (k + 1)) * (2 * (k + 1) + 1));
        localparam logic [63:0] DC = 64'((2 * (k + 1) - 1) * (2 * (k + 1)));
        localparam logic [MW-1:0] MS = MW'(((64'd1 << 42) + DS - 64'd1) / DS);
        localparam logic [MW-1:0] MC = MW'(((64'd1 << 42) + DC - 64'd1) / DC);

        logic [TW+31:0]    ps_prod, pc_prod;
        logic [TW+MW-1:0]  qs_prod, qc_prod;
        logic [TW-1:0]     ts_new, tc_new;

        assign ps_prod = (TW+32)'(tsb_reg[k]) * (TW+32)'(t2b_reg[k]);
        assign pc_prod = (TW+32)'(tcb_reg[k]) * (TW+32)'(t2b_reg[k]);
        assign qs_prod = (TW+MW)'(psa_reg[k]) * (TW+MW)'(MS);
        assign qc_prod = (TW+MW)'(pca_reg[k]) * (TW+MW)'(MC);
        assign ts_new  = TW'(qs_prod >> 42);
        assign tc_new  = TW'(qc_prod >> 42);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                va_reg[k]   <= 1'b0;
                vb_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                va_reg[k]   <= vb_reg[k];
                vb_reg[k+1] <= va_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                ea_reg[k]    <= eb_reg[k];
                oa_reg[k]    <= ob_reg[k];
                qa_reg[k]    <= qb_reg[k];
                t2a_reg[k]   <= t2b_reg[k];
                sva_reg[k]   <= svb_reg[k];
                cva_reg[k]   <= cvb_reg[k];
                psa_reg[k]   <= TW'(ps_prod >> 30);
                pca_reg[k]   <= TW'(pc_prod >> 30);
                eb_reg[k+1]  <= ea_reg[k];
                ob_reg[k+1]  <= oa_reg[k];
                qb_reg[k+1]  <= qa_reg[k];
                t2b_reg[k+1] <= t2a_reg[k];
                tsb_reg[k+1] <= ts_new;
                tcb_reg[k+1] <= tc_new;
                if (k % 2 == 0)
                begin
                    svb_reg[k+1] <= sva_reg[k] - $signed(SW'(ts_new));
                    cvb_reg[k+1] <= cva_reg[k] - $signed(SW'(tc_new));
                end
                else
                begin
                    svb_reg[k+1] <= sva_reg[k] + $signed(SW'(ts_new));
                    cvb_reg[k+1] <= cva_reg[k] + $signed(SW'(tc_new));
                end
            end
        end
    end

    // q1.15 conversion and quadrant
    function automatic logic signed [15:0] to_q15(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] r;
        r = (v + (SW'(1) << 14)) >>> 15;
        if (v < 0)
            return '0;
        else if (r > SW'(32767))
            return 16'sd32767;
        else
            return r[15:0];
    endfunction

    logic signed [15:0] cq, sq, c_next, s_next;
    assign cq = to_q15(cvb_reg[SIN_TERMS]);
    assign sq = to_q15(svb_reg[SIN_TERMS]);

    always_comb
    begin
        case (qb_reg[SIN_TERMS])
            2'd0:
            begin
                c_next = cq;
                s_next = sq;
            end
            2'd1:
            begin
                c_next = -sq;
                s_next = cq;
            end
            2'd2:
            begin
                c_next = -cq;
                s_next = -sq;
            end
            default:
            begin
                c_next = sq;
                s_next = -cq;
            end
        endcase
    end

    logic               vc_reg;
    logic signed [31:0] ec_reg, oc_reg;
    logic signed [15:0] c_reg, s_reg;

    logic               vm_reg;
    logic signed [47:0] ec_prod_reg, os_prod_reg, es_prod_reg, oc_prod_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg        <= 1'b0;
            vm_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vc_reg        <= vb_reg[SIN_TERMS];
            vm_reg        <= vc_reg;
            out_valid_reg <= vm_reg;
        end
    end

    // rounding to q16.16 with clipping
    logic signed [48:0] acc_e, acc_o;
    logic signed [48:0] rnd_e, rnd_o;
    logic               sat_e, sat_o;
    logic signed [31:0] res_e, res_o;

    assign acc_e = 49'(ec_prod_reg) - 49'(os_prod_reg);
    assign acc_o = 49'(es_prod_reg) + 49'(oc_prod_reg);
    assign rnd_e = (acc_e + 49'sd16384) >>> 15;
    assign rnd_o = (acc_o + 49'sd16384) >>> 15;

    always_comb
    begin
        sat_e = 1'b1;
        sat_o = 1'b1;
        if (rnd_e > 49'sd2147483647)
            res_e = 32'sh7fffffff;
        else if (rnd_e < -49'sd2147483648)
            res_e = 32'sh80000000;
        else
        begin
            res_e = rnd_e[31:0];
            sat_e = 1'b0;
        end
        if (rnd_o > 49'sd2147483647)
            res_o = 32'sh7fffffff;
        else if (rnd_o < -49'sd2147483648)
            res_o = 32'sh80000000;
        else
        begin
            res_o = rnd_o[31:0];
            sat_o = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ec_reg      <= eb_reg[SIN_TERMS];
            oc_reg      <= ob_reg[SIN_TERMS];
            c_reg       <= c_next;
            s_reg       <= s_next;
            ec_prod_reg <= 48'(ec_reg) * 48'(c_reg);
            os_prod_reg <= 48'(oc_reg) * 48'(s_reg);
            es_prod_reg <= 48'(ec_reg) * 48'(s_reg);
            oc_prod_reg <= 48'(oc_reg) * 48'(c_reg);
            result.rotated_even <= res_e;
            result.rotated_odd  <= res_o;
            result.saturated    <= sat_e || sat_o;
        end
    end

endmodule

`default_nettype wire

@@ design/rotary_position_embedding_top.sv @@
// top level of the rotary position embedding block
// depends on rope_pkg, rope_front, rope_queue, rope_back
`default_nettype none

// Rotates one even/odd Q16.16 pair per beat by the angle position * 10000^(-2j/HEAD_DIM),
// giving e*cos - o*sin and e*sin + o*cos rounded to Q16.16 with a saturation flag.
// One beat is taken every cycle when the result side keeps popping; an accepted beat
// passes the front register and the queue, then the back pipeline of 21 stages whose
// length is set by the eight series terms of sine and cosine, two stages each.
// Results come out in push order.
module rotary_position_embedding_top #(
    parameter int HEAD_DIM    = rope_pkg::HEAD_DIM_DEFAULT,
    parameter int QUEUE_DEPTH = rope_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 push,
    output logic                      full,
    input  wire rope_pkg::rope_in_t   item,
    output logic                      empty,
    input  wire logic                 pop,
    output rope_pkg::rope_out_t       result
);
    import rope_pkg::*;

    logic       wq_push;
    logic       wq_full;
    logic       wq_pop;
    logic       wq_empty;
    rope_work_t wq_in;
    rope_work_t wq_out;

    rope_front #(
        .HEAD_DIM (HEAD_DIM)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .full      (full),
        .item      (item),
        .work_push (wq_push),
        .work      (wq_in),
        .work_full (wq_full)
    );

    rope_queue #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (wq_push),
        .wr_data (wq_in),
        .q_full  (wq_full),
        .rd_en   (wq_pop),
        .rd_data (wq_out),
        .q_empty (wq_empty)
    );

    rope_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .work       (wq_out),
        .work_empty (wq_empty),
        .work_pop   (wq_pop),
        .result     (result),
        .empty      (empty),
        .pop        (pop)
    );

endmodule

`default_nettype wire

@@ dv/rotary_position_embedding_top_test.sv @@
// testbench for rotary_position_embedding_top: directed table then random pairs,
// each result checked against a stored expected value or an in-bench fixed-point rotation predictor
// depends on rope_pkg and rotary_position_embedding_top
`timescale 1ns / 1ps

module rotary_position_embedding_top_test;

    import rope_pkg::*;

    localparam int HEAD_DIM = 128;
    localparam int RANDOM_ITEMS = 400;

    typedef struct {
        rope_in_t  stim;
        bit        typed;
        rope_out_t want;
    } rope_row_t;

    logic      clk;
    logic      rst_n;
    logic      push;
    logic      full;
    rope_in_t  item;
    logic      empty;
    logic      pop;
    rope_out_t result;

    rope_out_t rotated_q[$];
    int        mismatches;
    int        idle_pct;
    int        stall_pct;

    rotary_position_embedding_top #(.HEAD_DIM(HEAD_DIM)) i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .full   (full),
        .item   (item),
        .empty  (empty),
        .pop    (pop),
        .result (result)
    );

    always
    begin
        clk = 1'b1;
        #10;
        clk = 1'b0;
        #10;
    end

    // turns per position for pair j, unsigned 0.32
    function automatic logic [31:0] pair_rate(input logic [6:0] j);
        logic [63:0] ex;
        logic [63:0] sh;
        logic [63:0] x;
        logic [63:0] acc;
        logic [63:0] term;
        logic [63:0] t;
        ex   = (64'(2 * j) * LOG2_10000_Q32) / 64'(HEAD_DIM);
        sh   = ex >> 32;
        x    = (64'(ex[31:0]) * LN2_Q32) >> 32;
        acc  = 64'd1 << 32;
        term = 64'd1 << 32;
        for (int k = 1; k <= 14; k++)
        begin
            term = ((term * x) >> 32) / 64'(k);
            if (k % 2 == 1)
                acc = acc - term;
            else
                acc = acc + term;
        end
        t = (acc * INV_2PI_Q32 + (64'd1 << 31)) >> 32;
        if (sh >= 32)
            return 32'd0;
        return 32'((t + ((64'd1 << sh) >> 1)) >> sh);
    endfunction

    function automatic longint unit_q15(input longint v);
        longint r;
        if (v < 0)
            return 0;
        r = (v + (64'sd1 << 14)) >>> 15;
        return (r > 32767) ? 32767 : r;
    endfunction

    function automatic void phase_sincos(input logic [31:0] phase,
                                         output longint c, output longint s);
        logic [63:0] th;
        logic [63:0] th2;
        logic [63:0] ts;
        logic [63:0] tc;
        longint      sv;
        longint      cv;
        longint      cq;
        longint      sq;
        th  = (64'(phase[29:0]) * 64'(HALF_PI_Q32)) >> 32;
        th2 = (th * th) >> 30;
        ts  = th;
        tc  = 64'd1 << 30;
        sv  = longint'(th);
        cv  = longint'(64'd1 << 30);
        for (int k = 1; k <= 8; k++)
        begin
            ts = ((ts * th2) >> 30) / 64'((2 * k) * (2 * k + 1));
            tc = ((tc * th2) >> 30) / 64'((2 * k - 1) * (2 * k));
            if (k % 2 == 1)
            begin
                sv = sv - longint'(ts);
                cv = cv - longint'(tc);
            end
            else
            begin
                sv = sv + longint'(ts);
                cv = cv + longint'(tc);
            end
        end
        cq = unit_q15(cv);
        sq = unit_q15(sv);
        case (phase[31:30])
            2'd0:
            begin
                c = cq;
                s = sq;
            end
            2'd1:
            begin
                c = -sq;
                s = cq;
            end
            2'd2:
            begin
                c = -cq;
                s = -sq;
            end
            default:
            begin
                c = sq;
                s = -cq;
            end
        endcase
    endfunction

    function automatic logic [31:0] clip_q16(input longint acc, inout logic clipped);
        logic [63:0] u;
        longint      v;
        u = 64'(acc) + (64'd1 << 62) + (64'd1 << 14);
        v = longint'(u >> 15) - (64'sd1 << 47);
        if (v > 64'sd2147483647)
        begin
            clipped = 1'b1;
            return 32'h7fffffff;
        end
        if (v < -64'sd2147483648)
        begin
            clipped = 1'b1;
            return 32'h80000000;
        end
        return 32'(v);
    endfunction

    function automatic rope_out_t rotate_pair(input rope_in_t in);
        rope_out_t   r;
        logic [31:0] phase;
        longint      c;
        longint      s;
        longint      e;
        longint      o;
        logic        clipped;
        phase   = pair_rate(in.pair_index) * 32'(in.position);
        phase_sincos(phase, c, s);
        e       = longint'(in.even_value);
        o       = longint'(in.odd_value);
        clipped = 1'b0;
        r.rotated_even = clip_q16(e * c - o * s, clipped);
        r.rotated_odd  = clip_q16(e * s + o * c, clipped);
        r.saturated    = clipped;
        return r;
    endfunction

    function automatic rope_row_t mk_row(input logic [31:0] e, input logic [31:0] o,
                                         input logic [6:0] j, input logic [15:0] p);
        rope_row_t row;
        row.stim  = '{even_value: e, odd_value: o, pair_index: j, position: p};
        row.typed = 1'b0;
        row.want  = '0;
        return row;
    endfunction

    task automatic send_beat(input rope_in_t in, input bit typed, input rope_out_t want);
        bit taken;
        do
        begin
            @(negedge clk);
            taken = ($urandom_range(99) >= idle_pct);
            push <= taken;
            if (taken)
                item <= in;
        end
        while (!taken);
        @(posedge clk);
        while (full)
            @(posedge clk);
        rotated_q.push_back(typed ? want : rotate_pair(in));
    endtask

    always @(negedge clk)
        if (rst_n)
            pop <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        rope_out_t want;
        if (rst_n && pop && !empty)
        begin
            if (rotated_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected beat: %h", result);
            end
            else
            begin
                want = rotated_q.pop_front();
                if (result.rotated_even !== want.rotated_even
                    || result.rotated_odd !== want.rotated_odd
                    || result.saturated !== want.saturated)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: even %h/%h odd %h/%h sat %b/%b (exp/act)",
                                 want.rotated_even, result.rotated_even,
                                 want.rotated_odd, result.rotated_odd,
                                 want.saturated, result.saturated);
                end
            end
        end
    end

    initial
    begin
        #5ms;
        $display("rotary_position_embedding_top_test: errors");
        $finish;
    end

    initial
    begin
        rope_row_t rows[$];
        rope_row_t row;
        rope_in_t  in;
        int        waited;
        mismatches = 0;
        idle_pct   = 0;
        stall_pct  = 0;
        rst_n      = 1'b0;
        push       = 1'b0;
        pop        = 1'b0;
        item       = '0;

        // zero pair gives zero at any angle
        row = mk_row(32'd0, 32'd0, 7'd0, 16'd0);
        row.typed = 1'b1;
        rows.push_back(row);
        row = mk_row(32'd0, 32'd0, 7'd127, 16'hffff);
        row.typed = 1'b1;
        rows.push_back(row);
        rows.push_back(mk_row(32'h7fffffff, 32'd0, 7'd0, 16'd0));
        rows.push_back(mk_row(32'h80000000, 32'h80000000, 7'd0, 16'd0));
        rows.push_back(mk_row(32'h7fffffff, 32'h7fffffff, 7'd0, 16'd1));
        rows.push_back(mk_row(32'h80000000, 32'h7fffffff, 7'd0, 16'd1));
        for (int p = 2; p <= 7; p++)
            rows.push_back(mk_row(32'h00010000, 32'hffff8000, 7'd0, 16'(p)));
        rows.push_back(mk_row(32'h12345678, 32'h9abcdef0, 7'd0, 16'hffff));
        rows.push_back(mk_row(32'h7fffffff, 32'h80000000, 7'd63, 16'd1000));
        rows.push_back(mk_row(32'h00020000, 32'h00030000, 7'd64, 16'd12345));
        rows.push_back(mk_row(32'hfffe0000, 32'h00050000, 7'd127, 16'hffff));
        rows.push_back(mk_row(32'h40000000, 32'h40000000, 7'd31, 16'h8000));
        rows.push_back(mk_row(32'hc0000000, 32'h3fffffff, 7'd1, 16'h5555));
        rows.push_back(mk_row(32'h55555555, 32'haaaaaaaa, 7'h55, 16'haaaa));
        rows.push_back(mk_row(32'haaaaaaaa, 32'h55555555, 7'h2a, 16'h5555));

        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (rows[i])
            send_beat(rows[i].stim, rows[i].typed, rows[i].want);

        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            case (n / (RANDOM_ITEMS / 4))
                0:
                begin
                    idle_pct  = 0;
                    stall_pct = 0;
                end
                1:
                begin
                    idle_pct  = 56;
                    stall_pct = 0;
                end
                2:
                begin
                    idle_pct  = 0;
                    stall_pct = 56;
                end
                default:
                begin
                    idle_pct  = 8;
                    stall_pct = 8;
                end
            endcase
            in.even_value = $urandom;
            in.odd_value  = $urandom;
            if ($urandom_range(3) == 0)
            begin
                in.even_value = $signed(in.even_value) >>> $urandom_range(31);
                in.odd_value  = $signed(in.odd_value) >>> $urandom_range(31);
            end
            in.pair_index = 7'($urandom_range(127));
            in.position   = ($urandom_range(1) == 0) ? 16'($urandom_range(65535))
                                                     : 16'($urandom_range(63));
            send_beat(in, 1'b0, '0);
        end
        @(negedge clk);
        push <= 1'b0;
        stall_pct = 0;

        waited = 0;
        while (rotated_q.size() != 0 && waited < 10000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (40) @(posedge clk);
        if (mismatches == 0 && rotated_q.size() == 0)
            $display("rotary_position_embedding_top_test: clean");
        else
            $display("rotary_position_embedding_top_test: errors");
        $finish;
    end

endmodule

@@ rotary_position_embedding_top.f @@
design/rope_pkg.sv
design/rope_front.sv
design/rope_queue.sv
design/rope_back.sv
design/rotary_position_embedding_top.sv
dv/rotary_position_embedding_top_test.sv
